>>> rtl/auto_pointer_layer_mode_assert.svh
// assertion macros for the auto pointer layer block
`ifndef AUTO_POINTER_LAYER_MODE_ASSERT_SVH
`define AUTO_POINTER_LAYER_MODE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define APL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("apl same-cycle check failed");

// next-cycle implication, disabled while in reset
`define APL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("apl next-cycle check failed");

`endif

>>> rtl/apl_pkg.sv
package apl_pkg;

	localparam int unsigned TIME_W  = 16;
	localparam int unsigned MOVE_W  = 15;
	localparam int unsigned DELTA_W = 16;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [MOVE_W-1:0] MOVE_MAX = 15'd32767;

	// commands
	localparam logic [CMD_W-1:0] CMD_MOTION  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_OTHER   = 2'd3;

	// mode codes as seen on the result channel
	localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WAITING   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLICKABLE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLICKING  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLICKED   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLICKED_HOLD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLICKABLE_HOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 3'd3;

	// register reset values
	localparam logic [TIME_W-1:0] CLICKED_HOLD_RST   = 16'd150;
	localparam logic [TIME_W-1:0] CLICKABLE_HOLD_RST = 16'd1400;
	localparam logic [TIME_W-1:0] WAIT_TIMEOUT_RST   = 16'd50;
	localparam logic [MOVE_W-1:0] MOVE_THRESHOLD_RST = 15'd0;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic [TIME_W-1:0]         now_ms;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] clicked_hold_ms;
		logic [TIME_W-1:0] clickable_hold_ms;
		logic [TIME_W-1:0] wait_timeout_ms;
		logic [MOVE_W-1:0] move_threshold;
	} cfg_t;

	typedef struct packed {
		logic              layer_active;
		logic [MODE_W-1:0] mode;
	} result_t;

endpackage

>>> rtl/apl_in_if.sv
interface apl_in_if;
	logic                                valid;
	logic                                ready;
	logic [apl_pkg::CMD_W-1:0]           cmd;
	logic signed [apl_pkg::DELTA_W-1:0]  dx;
	logic signed [apl_pkg::DELTA_W-1:0]  dy;
	logic [apl_pkg::TIME_W-1:0]          now_ms;

	modport source (output valid, cmd, dx, dy, now_ms, input ready);
	modport sink (input valid, cmd, dx, dy, now_ms, output ready);
endinterface

>>> rtl/apl_out_if.sv
interface apl_out_if;
	logic                       valid;
	logic                       ready;
	logic                       layer_active;
	logic [apl_pkg::MODE_W-1:0] mode;

	modport source (output valid, layer_active, mode, input ready);
	modport sink (input valid, layer_active, mode, output ready);
endinterface

>>> rtl/apl_cfg_if.sv
interface apl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [apl_pkg::CFG_IDX_W-1:0]  index;
	logic [apl_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/apl_cfg_regs.sv
module apl_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [apl_pkg::CFG_IDX_W-1:0]  index,
	input  logic [apl_pkg::CFG_DATA_W-1:0] data,
	output apl_pkg::cfg_t                  cfg
);

	apl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clicked_hold_ms   <= apl_pkg::CLICKED_HOLD_RST;
			cfg_q.clickable_hold_ms <= apl_pkg::CLICKABLE_HOLD_RST;
			cfg_q.wait_timeout_ms   <= apl_pkg::WAIT_TIMEOUT_RST;
			cfg_q.move_threshold    <= apl_pkg::MOVE_THRESHOLD_RST;
		end else if (we) begin
			case (index)
				apl_pkg::REG_CLICKED_HOLD:   cfg_q.clicked_hold_ms   <= data;
				apl_pkg::REG_CLICKABLE_HOLD: cfg_q.clickable_hold_ms <= data;
				apl_pkg::REG_WAIT_TIMEOUT:   cfg_q.wait_timeout_ms   <= data;
				apl_pkg::REG_MOVE_THRESHOLD: cfg_q.move_threshold    <= data[apl_pkg::MOVE_W-1:0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/apl_core.sv
module apl_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  apl_pkg::item_t   item,
	input  apl_pkg::cfg_t    cfg,
	output apl_pkg::result_t res
);

	typedef enum logic [4:0] {
		ST_NONE      = 5'b00001,
		ST_WAITING   = 5'b00010,
		ST_CLICKABLE = 5'b00100,
		ST_CLICKING  = 5'b01000,
		ST_CLICKED   = 5'b10000
	} mode_state_t;

	localparam int unsigned MAG_W = apl_pkg::DELTA_W + 1;
	localparam int unsigned SUM_W = MAG_W + 1;

	// magnitude of a 16-bit two's complement value, -32768 gives 32768
	function automatic logic [MAG_W-1:0] mag(input logic [apl_pkg::DELTA_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {v[apl_pkg::DELTA_W-1], v};
		mag = v[apl_pkg::DELTA_W-1] ? (MAG_W'(0) - ext) : ext;
	endfunction

	function automatic logic [apl_pkg::MODE_W-1:0] encode(input mode_state_t s);
		case (s)
			ST_WAITING:   encode = apl_pkg::MODE_WAITING;
			ST_CLICKABLE: encode = apl_pkg::MODE_CLICKABLE;
			ST_CLICKING:  encode = apl_pkg::MODE_CLICKING;
			ST_CLICKED:   encode = apl_pkg::MODE_CLICKED;
			default:      encode = apl_pkg::MODE_NONE;
		endcase
	endfunction

	mode_state_t                mode_q, mode_d;
	logic                       layer_q, layer_d;
	logic [apl_pkg::TIME_W-1:0] mark_q, mark_d;
	logic [apl_pkg::MOVE_W-1:0] moved_q, moved_d;

	logic [apl_pkg::TIME_W-1:0] elapsed;
	logic [MAG_W-1:0]           ax, ay;
	logic [SUM_W-1:0]           sum;
	logic [apl_pkg::MOVE_W-1:0] sat;
	logic                       moving;

	always_comb begin
		mode_d  = mode_q;
		layer_d = layer_q;
		mark_d  = mark_q;
		moved_d = moved_q;

		elapsed = item.now_ms - mark_q;
		ax      = mag(item.dx);
		ay      = mag(item.dy);
		moving  = (item.dx != '0) || (item.dy != '0);
		sum     = SUM_W'(moved_q) + SUM_W'(ax) + SUM_W'(ay);
		sat     = (sum > SUM_W'(apl_pkg::MOVE_MAX)) ? apl_pkg::MOVE_MAX : sum[apl_pkg::MOVE_W-1:0];

		case (item.cmd)
			apl_pkg::CMD_MOTION: begin
				if (moving) begin
					case (mode_q)
						ST_CLICKABLE: mark_d = item.now_ms;
						ST_CLICKING:  ;
						ST_WAITING: begin
							if (sat >= cfg.move_threshold) begin
								moved_d = '0;
								layer_d = 1'b1;
								mark_d  = item.now_ms;
								mode_d  = ST_CLICKABLE;
							end else begin
								moved_d = sat;
							end
						end
						default: begin
							mark_d  = item.now_ms;
							mode_d  = ST_WAITING;
							moved_d = '0;
						end
					endcase
				end else begin
					case (mode_q)
						ST_CLICKING: ;
						ST_CLICKABLE: begin
							if (elapsed > cfg.clickable_hold_ms) begin
								mode_d  = ST_NONE;
								layer_d = 1'b0;
							end
						end
						ST_CLICKED: begin
							if (elapsed > cfg.clicked_hold_ms) begin
								mode_d  = ST_NONE;
								layer_d = 1'b0;
							end
						end
						ST_WAITING: begin
							if (elapsed > cfg.wait_timeout_ms) begin
								moved_d = '0;
								mode_d  = ST_NONE;
							end
						end
						default: begin
							moved_d = '0;
							mode_d  = ST_NONE;
						end
					endcase
				end
			end
			apl_pkg::CMD_PRESS: begin
				if (layer_q) mode_d = ST_CLICKING;
			end
			apl_pkg::CMD_RELEASE: begin
				if (layer_q) begin
					mark_d = item.now_ms;
					mode_d = ST_CLICKED;
				end
			end
			default: begin
				mode_d  = ST_NONE;
				layer_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ST_NONE;
			layer_q <= 1'b0;
			mark_q  <= '0;
			moved_q <= '0;
		end else if (en) begin
			mode_q  <= mode_d;
			layer_q <= layer_d;
			mark_q  <= mark_d;
			moved_q <= moved_d;
		end
	end

	assign res.layer_active = layer_d;
	assign res.mode         = encode(mode_d);

endmodule

>>> rtl/auto_pointer_layer_mode.sv
// Auto pointer-layer controller. Every beat on the sample channel (motion,
// button press, button release or other key press, each with its millisecond
// timestamp) yields exactly one beat on the status channel carrying the layer
// flag and the mode after that item. A sample beat is taken every cycle unless
// back-pressure on the status channel holds it: the beat is held in an input
// register, the mode update runs as logic from there into the result register,
// so the status beat for a sample is offered once it has passed through both
// registers, and the state loop (mode, time mark, movement sum, layer flag)
// closes through the core's state registers, which load with the result register.
// Back-pressure on the status channel stalls the input register; the input side
// keeps taking beats while the result register still has room behind it. The
// cfg channel is always ready; writes take effect on the next item and are meant
// to be made while the block is idle.
`include "auto_pointer_layer_mode_assert.svh"

module auto_pointer_layer_mode (
	input logic         clk,
	input logic         arst_n,
	apl_in_if.sink      sample,
	apl_out_if.source   status,
	apl_cfg_if.sink     cfg
);

	// input register
	logic             valid_s1;
	apl_pkg::item_t   item_s1;

	// result register
	logic             res_valid_q;
	apl_pkg::result_t res_q;

	apl_pkg::result_t res_next;
	apl_pkg::cfg_t    cfg_regs;
	logic             adv;

	// terms for the checks at the end
	logic             status_off;
	logic             mode_idle;
	logic             other_adv;
	logic             dropped_out;

	// the item in the input register moves on when the result register is free or draining
	assign adv          = valid_s1 && (!res_valid_q || status.ready);
	assign sample.ready = !valid_s1 || adv;

	// configuration never stalls
	assign cfg.ready = 1'b1;

	apl_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg.valid && cfg.ready),
		.index  (cfg.index),
		.data   (cfg.data),
		.cfg    (cfg_regs)
	);

	// state update happens as the item leaves the input register
	apl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg_regs),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1.cmd    <= sample.cmd;
			item_s1.dx     <= sample.dx;
			item_s1.dy     <= sample.dy;
			item_s1.now_ms <= sample.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (status.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_next;
		end
	end

	assign status.valid        = res_valid_q;
	assign status.layer_active = res_q.layer_active;
	assign status.mode         = res_q.mode;

	assign status_off  = status.valid && !status.layer_active;
	assign mode_idle   = (status.mode == apl_pkg::MODE_NONE) ||
		(status.mode == apl_pkg::MODE_WAITING);
	assign other_adv   = adv && (item_s1.cmd == apl_pkg::CMD_OTHER);
	assign dropped_out = status_off && (status.mode == apl_pkg::MODE_NONE);

	// a beat leaving the input register always lands in the result register
	`APL_ASSERT_NXT(a_adv_fills_result, clk, arst_n, adv, res_valid_q)

	// the input side never takes a beat while a full input register is blocked
	`APL_ASSERT_IMP(a_no_overrun, clk, arst_n, valid_s1 && sample.ready, !res_valid_q || status.ready)

	// with the layer off, only none or waiting can be reported
	`APL_ASSERT_IMP(a_layer_off_mode, clk, arst_n, status_off, mode_idle)

	// another key press always drops the layer
	`APL_ASSERT_NXT(a_other_key_drops, clk, arst_n, other_adv, dropped_out)

endmodule
